// ===== hw/rtl/pbt_pkg.sv =====
// Package for the piece bitmap tracker: codes, controller types and shared constants.
package pbt_pkg;

  // Default bitmap capacity in pieces
  localparam int unsigned MaxPiecesDef = 65536;

  // Field widths fixed by the word format
  localparam int unsigned PieceW = 16;
  localparam int unsigned ByteIdxW = 13;
  localparam int unsigned CountW = 17;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_MARK    = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_COMPARE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_NOCFG = 2'd2,
    STS_LEN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EVAL,
    FSM_EMIT
  } fsm_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_we;       // clearing pass writes one zero byte
    logic accept;       // input word taken, bitmap byte read
    logic single_fire;  // one-word result written, state committed
    logic multi_start;  // compare hit mask loaded for emission
    logic emit_fire;    // one compare hit written out
  } pbt_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // clearing pass at final byte
    logic slot_free;  // output register can take a word
    logic multi;      // compare found at least one missing piece
    logic emit_last;  // one hit left in the mask
  } pbt_sts_t;

endpackage

// ===== hw/rtl/pbt_ctrl.sv =====
// Controller state machine of the piece bitmap tracker.
module pbt_ctrl
  import pbt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid_i,
  output logic     s_axis_tready_o,
  input  pbt_sts_t sts_i,
  output pbt_ctl_t ctl_o
);

  fsm_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_CLEAR: begin
        if (sts_i.clr_last) state_d = FSM_IDLE;
      end
      FSM_IDLE: begin
        if (s_axis_tvalid_i) state_d = FSM_EVAL;
      end
      FSM_EVAL: begin
        if (sts_i.multi) state_d = FSM_EMIT;
        else if (sts_i.slot_free) state_d = FSM_IDLE;
      end
      FSM_EMIT: begin
        if (sts_i.slot_free && sts_i.emit_last) state_d = FSM_IDLE;
      end
      default: state_d = FSM_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      FSM_CLEAR: begin
        ctl_o.clr_we = 1'b1;
      end
      FSM_IDLE: begin
        s_axis_tready_o = 1'b1;
        ctl_o.accept = s_axis_tvalid_i;
      end
      FSM_EVAL: begin
        ctl_o.multi_start = sts_i.multi;
        ctl_o.single_fire = !sts_i.multi && sts_i.slot_free;
      end
      FSM_EMIT: begin
        ctl_o.emit_fire = sts_i.slot_free;
      end
      default: ctl_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/pbt_datapath.sv =====
// Datapath of the piece bitmap tracker: bitmap memory, count, compare hits, output register.
module pbt_datapath
  import pbt_pkg::*;
#(
  parameter int unsigned MAX_PIECES = MaxPiecesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,
  input  logic [1:0]          in_cmd_i,
  input  logic [PieceW-1:0]   in_piece_i,
  input  logic [ByteIdxW-1:0] in_bidx_i,
  input  logic [7:0]          in_bval_i,
  input  logic                in_fin_i,
  input  logic                m_axis_tready_i,
  output logic                m_axis_tvalid_o,
  output logic [39:0]         m_axis_tdata_o,
  output logic                m_axis_tlast_o,
  input  pbt_ctl_t            ctl_i,
  output pbt_sts_t            sts_o
);

  localparam int unsigned MapBytes = (MAX_PIECES + 7) / 8;
  localparam int unsigned AddrW = (MapBytes > 1) ? $clog2(MapBytes) : 1;
  localparam int unsigned NbW = CountW - 2;

  // Configuration and count
  logic [CountW-1:0] total_q, held_q, held_nx, eff_total;
  logic [NbW-1:0]    nbytes;

  // Bitmap memory
  logic [7:0]       bitmap_q [MapBytes];
  logic [7:0]       rdata_q;
  logic [AddrW-1:0] rd_addr, wr_addr, addr_q, clr_cnt_q;
  logic [7:0]       wr_data;
  logic             mem_we;

  // Item held during evaluation
  cmd_e                cmd_q;
  logic [PieceW-1:0]   piece_q;
  logic [ByteIdxW-1:0] bidx_q;
  logic [7:0]          bval_q;
  logic                fin_q;

  // Evaluation results
  logic [PieceW-1:0] res_idx;
  logic              res_hit;
  status_e           res_sts;
  logic              mark_set, load_wr, multi;
  logic [7:0]        piece_mask, cmp_mask;
  logic              bit_set, prange, brange;

  // Compare emission
  logic [7:0] emit_mask_q, emit_onehot;
  logic [2:0] emit_pos;
  logic       emit_last;

  // Output register
  logic              out_vld_q, out_hit_q, out_cpl_q, out_last_q;
  logic [PieceW-1:0] out_idx_q;
  status_e           out_sts_q;
  logic [CountW-1:0] out_held_q;
  logic              slot_free;

  // Effective total clamped to capacity, and bitmap length in bytes
  assign eff_total = (32'(total_q) > 32'(MAX_PIECES)) ? CountW'(MAX_PIECES) : total_q;
  assign nbytes    = NbW'((18'(eff_total) + 18'd7) >> 3);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctl_i.clr_we) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end
  assign sts_o.clr_last = (clr_cnt_q == AddrW'(MapBytes - 1));

  // Read address straight from the input word
  assign rd_addr = (in_cmd_i inside {CMD_MARK, CMD_CHECK})
                 ? AddrW'(in_piece_i[PieceW-1:3]) : AddrW'(in_bidx_i);

  // Item registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q   <= cmd_e'(in_cmd_i);
      piece_q <= in_piece_i;
      bidx_q  <= in_bidx_i;
      bval_q  <= in_bval_i;
      fin_q   <= in_fin_i;
      addr_q  <= rd_addr;
    end
  end

  // Memory read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      rdata_q <= bitmap_q[rd_addr];
    end
  end

  // Memory write port: clearing pass, mark or load
  assign mem_we  = ctl_i.clr_we || (ctl_i.single_fire && (mark_set || load_wr));
  assign wr_addr = ctl_i.clr_we ? clr_cnt_q : addr_q;
  assign wr_data = ctl_i.clr_we ? 8'h00 : (load_wr ? bval_q : (rdata_q | piece_mask));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_q[wr_addr] <= wr_data;
    end
  end

  // Piece bit and range checks
  assign piece_mask = 8'h80 >> piece_q[2:0];
  assign bit_set    = |(rdata_q & piece_mask);
  assign prange     = ({1'b0, piece_q} >= eff_total);
  assign brange     = ({2'b0, bidx_q} >= nbytes);

  // Pieces the peer has and the local bitmap lacks, bit i is piece bidx*8+i
  always_comb begin
    cmp_mask = '0;
    for (int i = 0; i < 8; i++) begin
      if ({1'b0, bidx_q, 3'(i)} < eff_total) begin
        cmp_mask[i] = bval_q[7-i] && !rdata_q[7-i];
      end
    end
  end

  // Command evaluation
  always_comb begin
    res_idx  = '0;
    res_hit  = 1'b0;
    res_sts  = STS_OK;
    mark_set = 1'b0;
    load_wr  = 1'b0;
    multi    = 1'b0;
    if (eff_total == '0) begin
      res_sts = STS_NOCFG;
    end else if (cmd_q inside {CMD_MARK, CMD_CHECK}) begin
      if (prange) begin
        res_sts = STS_RANGE;
      end else begin
        res_idx = piece_q;
        if (cmd_q == CMD_CHECK) begin
          res_hit = bit_set;
        end else begin
          res_hit  = !bit_set;
          mark_set = !bit_set;
        end
      end
    end else if (brange) begin
      res_sts = STS_RANGE;
    end else if (cmd_q == CMD_LOAD) begin
      load_wr = 1'b1;
    end else if (fin_q && ({2'b0, bidx_q} + NbW'(1) != nbytes)) begin
      res_sts = STS_LEN;
    end else begin
      multi = |cmp_mask;
    end
  end
  assign sts_o.multi = multi;

  // Held count after a mark, saturating
  assign held_nx = (mark_set && held_q != '1) ? held_q + CountW'(1) : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (ctl_i.single_fire) begin
      held_q <= held_nx;
    end
  end

  // Lowest pending hit of the compare mask
  always_comb begin
    emit_pos = '0;
    for (int i = 7; i >= 0; i--) begin
      if (emit_mask_q[i]) emit_pos = 3'(i);
    end
  end
  assign emit_onehot     = 8'h01 << emit_pos;
  assign emit_last       = ((emit_mask_q & ~emit_onehot) == '0);
  assign sts_o.emit_last = emit_last;

  always_ff @(posedge clk_i) begin
    if (ctl_i.multi_start) begin
      emit_mask_q <= cmp_mask;
    end else if (ctl_i.emit_fire) begin
      emit_mask_q <= emit_mask_q & ~emit_onehot;
    end
  end

  // Output register
  assign slot_free       = !out_vld_q || m_axis_tready_i;
  assign sts_o.slot_free = slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.single_fire || ctl_i.emit_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.single_fire) begin
      out_idx_q  <= res_idx;
      out_hit_q  <= res_hit;
      out_sts_q  <= res_sts;
      out_held_q <= held_nx;
      out_cpl_q  <= (held_nx == eff_total);
      out_last_q <= 1'b1;
    end else if (ctl_i.emit_fire) begin
      out_idx_q  <= {bidx_q, emit_pos};
      out_hit_q  <= 1'b1;
      out_sts_q  <= STS_OK;
      out_held_q <= held_q;
      out_cpl_q  <= (held_q == eff_total);
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {3'b000, out_cpl_q, out_held_q, out_sts_q, out_hit_q, out_idx_q};

  // Bitmap is never written in the cycle a word is taken
  a_no_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && ctl_i.accept))
    else $error("bitmap write collides with input accept");

  // Held count moves only when a one-word result commits
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.single_fire |=> $stable(held_q))
    else $error("held count changed without a commit");

  // Held count never decreases
  a_held_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> held_q >= $past(held_q))
    else $error("held count decreased");

  // A compare hit is emitted only from a nonempty mask
  a_emit_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit_fire |-> emit_mask_q != '0)
    else $error("compare emission from empty mask");

  // Results are written only into a free output register
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.single_fire || ctl_i.emit_fire) |-> slot_free)
    else $error("result overwrote a pending output word");

endmodule

// ===== hw/rtl/piece_bitmap_tracker_top.sv =====
// Top level of the piece bitmap tracker: controller plus datapath.
//
// Channel   Dir  Signals                     Contents
// s_axis    in   tvalid/tready/tdata/tuser/tlast  command word; tuser cmd, tlast final byte
// m_axis    out  tvalid/tready/tdata/tlast   result word; tlast last result of a command
// cfg       in   cfg_we_i/cfg_wdata_i        total_pieces, written when cfg_we_i is high
//
// Load, mark and check: accept with bitmap byte read, then evaluate and write.
// Compare gives one result, or N results for N missing pieces, one a cycle unless stalled.
// After reset a clearing pass zeroes all (MAX_PIECES+7)/8 bitmap bytes, one byte a cycle
// (8192 by default); s_axis_tready_o stays low during it, cfg writes are taken throughout.
// The output register holds a word until taken; evaluate or emit waits while it is full
// and m_axis_tready_i is low; the next word is accepted once the last result is registered.
module piece_bitmap_tracker_top
  import pbt_pkg::*;
#(
  parameter int unsigned MAX_PIECES = MaxPiecesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [15:0] piece_index, [28:16] byte_index, [36:29] byte_value, [39:37] zero
  input  logic [39:0]       s_axis_tdata_i,
  // [1:0] cmd
  input  logic [1:0]        s_axis_tuser_i,
  input  logic              s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [15:0] found_index, [16] hit, [18:17] status, [35:19] held_count, [36] complete,
  // [39:37] zero
  output logic [39:0]       m_axis_tdata_o,
  output logic              m_axis_tlast_o
);

  pbt_ctl_t ctl;
  pbt_sts_t sts;

  pbt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .ctl_o           (ctl)
  );

  pbt_datapath #(
    .MAX_PIECES (MAX_PIECES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_cmd_i        (s_axis_tuser_i),
    .in_piece_i      (s_axis_tdata_i[15:0]),
    .in_bidx_i       (s_axis_tdata_i[28:16]),
    .in_bval_i       (s_axis_tdata_i[36:29]),
    .in_fin_i        (s_axis_tlast_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .ctl_i           (ctl),
    .sts_o           (sts)
  );

endmodule

// ===== verif/piece_bitmap_tracker_top_tb.sv =====
// Piece bitmap tracker testbench: random bursts and stalls, self-checking tracker model.
`timescale 1ns / 100ps

module piece_bitmap_tracker_top_tb
  import pbt_pkg::*;
();

  localparam int unsigned MaxPieces = MaxPiecesDef;
  localparam int unsigned MapBytes = (MaxPieces + 7) / 8;
  localparam int unsigned CountMax = 32'h1FFFF;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 20;

  // One command word as the sender sees it
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] piece;
    logic [12:0] byte_idx;
    logic [7:0]  byte_val;
    logic        final_byte;
  } request_t;

  // One result word
  typedef struct packed {
    logic [15:0] found_index;
    logic        hit;
    status_e     status;
    logic [16:0] held_count;
    logic        complete;
    logic        last_word;
  } result_t;

  // Tracks held pieces and checks each result word against the oldest one due
  class piece_scoreboard;
    logic [7:0]  held_map [MapBytes];
    int unsigned held_cnt;
    int unsigned total_reg;
    result_t     due_results [$];
    int unsigned mismatch_count;

    function new();
      foreach (held_map[i]) held_map[i] = 8'h00;
      held_cnt = 0;
      total_reg = 0;
      mismatch_count = 0;
    endfunction

    function int unsigned eff_total();
      return (total_reg > MaxPieces) ? MaxPieces : total_reg;
    endfunction

    function void set_total(int unsigned value);
      total_reg = value;
    endfunction

    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= MaxReports) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    function void add_result(int unsigned found, bit hit, status_e st, bit last_word);
      result_t e;
      e.found_index = 16'(found);
      e.hit = hit;
      e.status = st;
      e.held_count = 17'(held_cnt);
      e.complete = (held_cnt == eff_total());
      e.last_word = last_word;
      due_results.push_back(e);
    endfunction

    // Apply one accepted command to the tracked bitmap and queue its results
    function void note_command(request_t r);
      int unsigned eff, nb, bidx, pos, p;
      logic [7:0]  mask, local_byte;
      int unsigned missing [$];
      eff = eff_total();
      nb = (eff + 7) / 8;
      bidx = r.byte_idx;
      if (eff == 0) begin
        add_result(0, 0, STS_NOCFG, 1);
        return;
      end
      if (r.cmd inside {CMD_MARK, CMD_CHECK}) begin
        if (r.piece >= eff) begin
          add_result(0, 0, STS_RANGE, 1);
          return;
        end
        pos = r.piece >> 3;
        mask = 8'h80 >> r.piece[2:0];
        if (r.cmd == CMD_CHECK) begin
          add_result(r.piece, (held_map[pos] & mask) != 0, STS_OK, 1);
        end else if ((held_map[pos] & mask) != 0) begin
          add_result(r.piece, 0, STS_OK, 1);
        end else begin
          held_map[pos] = held_map[pos] | mask;
          if (held_cnt < CountMax) held_cnt++;
          add_result(r.piece, 1, STS_OK, 1);
        end
        return;
      end
      if (bidx >= nb) begin
        add_result(0, 0, STS_RANGE, 1);
        return;
      end
      if (r.cmd == CMD_LOAD) begin
        held_map[bidx] = r.byte_val;
        add_result(0, 0, STS_OK, 1);
        return;
      end
      // compare: wrong place for the final peer byte
      if (r.final_byte && bidx + 1 != nb) begin
        add_result(0, 0, STS_LEN, 1);
        return;
      end
      local_byte = held_map[bidx];
      for (int i = 0; i < 8; i++) begin
        p = bidx * 8 + i;
        if (p < eff && r.byte_val[7-i] && !local_byte[7-i]) missing.push_back(p);
      end
      if (missing.size() == 0) begin
        add_result(0, 0, STS_OK, 1);
        return;
      end
      foreach (missing[k]) add_result(missing[k], 1, STS_OK, k == missing.size() - 1);
    endfunction

    task check_result(result_t got);
      result_t exp_r;
      if (due_results.size() == 0) begin
        report($sformatf("result word %h with none due", got));
        return;
      end
      exp_r = due_results.pop_front();
      if (got.found_index != exp_r.found_index)
        report($sformatf("found_index %0d, want %0d", got.found_index, exp_r.found_index));
      if (got.hit != exp_r.hit)
        report($sformatf("hit %0d, want %0d", got.hit, exp_r.hit));
      if (got.status != exp_r.status)
        report($sformatf("status %0d, want %0d", got.status, exp_r.status));
      if (got.held_count != exp_r.held_count)
        report($sformatf("held_count %0d, want %0d", got.held_count, exp_r.held_count));
      if (got.complete != exp_r.complete)
        report($sformatf("complete %0d, want %0d", got.complete, exp_r.complete));
      if (got.last_word != exp_r.last_word)
        report($sformatf("last %0d, want %0d", got.last_word, exp_r.last_word));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  piece_scoreboard sb;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned cycle_count = 0;

  piece_bitmap_tracker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  // Run-time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: switches between no stalls, coin-flip stalls and long stalls
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= 1'($urandom_range(0, 1));
      default: m_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result monitor
  always @(posedge clk_i) begin
    result_t got;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      got.found_index = m_axis_tdata_o[15:0];
      got.hit = m_axis_tdata_o[16];
      got.status = status_e'(m_axis_tdata_o[18:17]);
      got.held_count = m_axis_tdata_o[35:19];
      got.complete = m_axis_tdata_o[36];
      got.last_word = m_axis_tlast_o;
      sb.check_result(got);
    end
  end

  // Send one command word; bursts of random length with random gaps between
  task automatic send_word(request_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_tdata <= {3'b000, r.byte_val, r.byte_idx, r.piece};
    s_tuser <= r.cmd;
    s_tlast <= r.final_byte;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(r);
  endtask

  task automatic send_fields(cmd_e c, int unsigned piece, int unsigned bidx,
                             int unsigned bval, bit fin);
    request_t r;
    r.cmd = c;
    r.piece = 16'(piece);
    r.byte_idx = 13'(bidx);
    r.byte_val = 8'(bval);
    r.final_byte = fin;
    send_word(r);
  endtask

  // Register write once the block has drained
  task automatic write_total(logic [16:0] value);
    s_valid <= 1'b0;
    burst_left = 0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_total(value);
  endtask

  // Random command, mostly in range, with a bias toward low pieces so they repeat
  task automatic send_random(int unsigned eff);
    int unsigned nb, piece, bidx, win;
    cmd_e        c;
    bit          fin;
    nb = (eff + 7) / 8;
    c = cmd_e'($urandom_range(0, 3));
    fin = ($urandom_range(0, 3) == 0);
    if (eff == 0) begin
      piece = $urandom_range(0, 65535);
      bidx = $urandom_range(0, 8191);
    end else begin
      win = (eff < 64) ? eff : 64;
      if ($urandom_range(0, 7) == 0 && eff < MaxPieces) piece = $urandom_range(eff, 65535);
      else if ($urandom_range(0, 1) == 0) piece = $urandom_range(0, win - 1);
      else piece = $urandom_range(0, eff - 1);
      if ($urandom_range(0, 7) == 0 && nb < MapBytes) bidx = $urandom_range(nb, 8191);
      else if ($urandom_range(0, 1) == 0) bidx = $urandom_range(0, (win + 7) / 8 - 1);
      else bidx = $urandom_range(0, nb - 1);
      if (c == CMD_COMPARE && $urandom_range(0, 1) == 0) fin = (bidx == nb - 1);
    end
    send_fields(c, piece, bidx, $urandom_range(0, 255), fin);
  endtask

  // Random traffic: whole peer bitmaps, fill runs of marks, and single commands
  task automatic random_items(int unsigned eff, int unsigned n_items);
    int unsigned sent, nb, stop_at, start;
    nb = (eff + 7) / 8;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 3 && eff != 0 && nb <= 32) begin
        // peer bitmap front to back; now and then the final flag comes early
        stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nb - 1) : nb - 1;
        for (int b = 0; b <= stop_at; b++)
          send_fields(CMD_COMPARE, $urandom_range(0, 65535), b, $urandom_range(0, 255),
                      b == stop_at);
        sent += stop_at + 1;
      end else if ($urandom_range(0, 9) == 0 && eff != 0 && eff <= 16) begin
        // mark every piece, starting anywhere
        start = $urandom_range(0, eff - 1);
        for (int k = 0; k < eff; k++)
          send_fields(CMD_MARK, (start + k) % eff, $urandom_range(0, 8191),
                      $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        sent += eff;
      end else begin
        send_random(eff);
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [16:0] total, int unsigned n_items);
    write_total(total);
    random_items((total > MaxPieces) ? MaxPieces : total, n_items);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;

    // not configured
    write_total(17'd0);
    send_fields(CMD_LOAD, 0, 0, 8'hFF, 1'b0);
    send_fields(CMD_MARK, 3, 0, 0, 1'b0);
    send_fields(CMD_CHECK, 65535, 8191, 0, 1'b1);
    send_fields(CMD_COMPARE, 0, 0, 8'hFF, 1'b1);
    random_items(0, 8);

    run_phase(17'd1, 20);

    // 13 pieces: two bytes, three spare bits at the end
    write_total(17'd13);
    send_fields(CMD_LOAD, 0, 1, 8'hFF, 1'b0);      // spare bits set too
    send_fields(CMD_CHECK, 12, 0, 0, 1'b0);
    send_fields(CMD_MARK, 12, 0, 0, 1'b0);         // already held, not counted
    send_fields(CMD_LOAD, 0, 1, 8'h00, 1'b0);
    send_fields(CMD_MARK, 0, 0, 0, 1'b0);
    send_fields(CMD_MARK, 0, 0, 0, 1'b0);
    send_fields(CMD_MARK, 12, 0, 0, 1'b0);
    send_fields(CMD_CHECK, 13, 0, 0, 1'b0);        // out of range
    send_fields(CMD_MARK, 65535, 0, 0, 1'b0);
    send_fields(CMD_LOAD, 0, 2, 8'h55, 1'b0);
    send_fields(CMD_COMPARE, 0, 8191, 8'hFF, 1'b1);
    send_fields(CMD_COMPARE, 0, 0, 8'hFF, 1'b0);   // seven missing
    send_fields(CMD_COMPARE, 0, 1, 8'hFF, 1'b1);   // spare bits ignored
    send_fields(CMD_COMPARE, 0, 0, 8'h80, 1'b1);   // final flag on the wrong byte
    send_fields(CMD_COMPARE, 0, 1, 8'h08, 1'b1);   // nothing missing
    random_items(13, 30);

    run_phase(17'd8, 30);
    run_phase(17'd37, 40);
    run_phase(17'd200, 40);

    // full capacity
    write_total(17'd65536);
    send_fields(CMD_MARK, 65535, 0, 0, 1'b0);
    send_fields(CMD_CHECK, 65535, 0, 0, 1'b0);
    send_fields(CMD_LOAD, 0, 8191, 8'hFE, 1'b0);
    send_fields(CMD_COMPARE, 0, 8191, 8'hFF, 1'b1);
    send_fields(CMD_COMPARE, 0, 8191, 8'h00, 1'b0);
    send_fields(CMD_COMPARE, 0, 0, 8'hFF, 1'b1);
    random_items(MaxPieces, 30);

    run_phase(17'h1FFFF, 25);
    run_phase(17'd5, 30);

    s_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
